// ----- hdl/fir49_pkg.sv -----
// fir49_pkg: shared types, widths and default tap weights for the 49-tap fir filter
// no dependencies; imported by every module of the filter but fir49_ram
`timescale 1ns / 1ps

package fir49_pkg;

    // fixed field widths
    localparam int COEF_W              = 24;
    localparam int OUT_W               = 26;
    localparam int IDX_W               = 6;
    localparam int OUT_TDATA_W         = 32;
    localparam int TAP_ARG_W           = 9;

    // defaults for the top-level parameters
    localparam int DEFAULT_NUM_TAPS    = 49;
    localparam int DEFAULT_FRAC_BITS   = 21;
    localparam int DEFAULT_SAMPLE_BITS = 16;

    // number of default taps held in the table below
    localparam int DEFAULT_TAP_COUNT   = 49;

    // default low-pass weights, signed with 21 fraction bits
    localparam logic signed [COEF_W-1:0] DEFAULT_TAPS [DEFAULT_TAP_COUNT] = '{
        24'sd9733,    24'sd15471,   -24'sd5049,   -24'sd14911,  24'sd6848,
        24'sd128,     -24'sd19624,  24'sd8336,    24'sd9183,    -24'sd27925,
        24'sd6391,    24'sd23983,   -24'sd37599,  -24'sd2252,   24'sd46682,
        -24'sd47138,  -24'sd22805,  24'sd83041,   -24'sd55201,  -24'sd70793,
        24'sd157703,  -24'sd60603,  -24'sd252402, 24'sd603816,  24'sd1335599,
        24'sd603816,  -24'sd252402, -24'sd60603,  24'sd157703,  -24'sd70793,
        -24'sd55201,  24'sd83041,   -24'sd22805,  -24'sd47138,  24'sd46682,
        -24'sd2252,   -24'sd37599,  24'sd23983,   24'sd6391,    -24'sd27925,
        24'sd9183,    24'sd8336,    -24'sd19624,  24'sd128,     24'sd6848,
        -24'sd14911,  -24'sd5049,   24'sd15471,   24'sd9733
    };

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_SCALE,
        ST_EMIT
    } t_state;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
        logic scale;
    } t_mac_ctrl;

    // reset weight of one tap; taps past the default set are zero
    function automatic logic signed [COEF_W-1:0] default_tap(input logic [TAP_ARG_W-1:0] idx);
        logic signed [COEF_W-1:0] w;
        w = '0;
        if (idx < TAP_ARG_W'(DEFAULT_TAP_COUNT)) begin
            w = DEFAULT_TAPS[idx[IDX_W-1:0]];
        end
        return w;
    endfunction

endpackage

// ----- hdl/fir_filter_49_tap.sv -----
// fir_filter_49_tap: top level of the 49-tap fir filter, stream ports and storage
// depends on fir49_pkg, fir49_ram, fir49_mac, fir49_seq
`timescale 1ns / 1ps

// Direct-form FIR filter over NUM_TAPS taps with one shared multiplier. A beat with
// tuser low carries a sample: it enters the delay line (a circular buffer in ram) and,
// when filtering is enabled, the sequencer walks every tap through the single
// multiply-accumulate unit, one tap per cycle. After the tap walk the sum is scaled and
// the output stage loads the filtered beat into the output register; the next beat is
// taken only once the sequencer is back in idle, so no new sample enters while one is
// being filtered. With filtering disabled the raw sample goes straight to the output
// stage. A held output beat keeps the sequencer in its output stage and holds off the
// next input beat. A beat with tuser high writes one coefficient as it is taken and
// gives no output beat; an index past the last tap is ignored. The output register
// holds a finished result while the next beat is taken. Coefficients reset to the
// default low-pass weights and the delay line to zero at once through per-entry valid
// bits, so no clearing pass follows reset.

module fir_filter_49_tap
    import fir49_pkg::*;
#(
    parameter int NUM_TAPS    = DEFAULT_NUM_TAPS,
    parameter int FRAC_BITS   = DEFAULT_FRAC_BITS,
    parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS,
    localparam int IN_TDATA_W = ((SAMPLE_BITS + IDX_W + COEF_W + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration: filter_enable
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_wdata,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // sample, coef_index, coef_value, zero pad
    input  logic                   s_axis_tuser,  // op
    // output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // filtered, zero pad
);

    localparam int TAP_AW = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
    localparam int PTR_W  = TAP_AW + 1;

    // input beat fields
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic [IDX_W-1:0]              in_coef_index;
    logic signed [COEF_W-1:0]      in_coef_value;

    assign in_sample     = s_axis_tdata[SAMPLE_BITS-1:0];
    assign in_coef_index = s_axis_tdata[SAMPLE_BITS +: IDX_W];
    assign in_coef_value = s_axis_tdata[SAMPLE_BITS + IDX_W +: COEF_W];

    t_state                  state;
    t_mac_ctrl               mac_ctrl;
    logic [TAP_AW-1:0]       tap;
    logic                    emit;
    logic                    in_beat;
    logic                    coef_we;
    logic                    samp_we;
    logic                    out_free;
    logic                    r_enable;
    logic [TAP_AW-1:0]       r_ptr;
    logic [TAP_AW-1:0]       ptr_next;
    logic [PTR_W-1:0]        ptr_diff;
    logic [TAP_AW-1:0]       d_raddr;
    logic [TAP_AW-1:0]       coef_waddr;
    logic [NUM_TAPS-1:0]     r_dvalid;
    logic [NUM_TAPS-1:0]     r_cvalid;
    logic                    r_dvld_rd;
    logic                    r_cvld_rd;
    logic [TAP_AW-1:0]       r_caddr_rd;
    logic [SAMPLE_BITS-1:0]  d_rdata;
    logic [COEF_W-1:0]       c_rdata;
    logic signed [SAMPLE_BITS-1:0] mac_sample;
    logic signed [COEF_W-1:0]      mac_coef;
    logic signed [OUT_W-1:0]       mac_result;
    logic signed [OUT_W-1:0]       r_raw;
    logic                          r_use_raw;
    logic                          r_out_valid;
    logic [OUT_W-1:0]              r_out_data;

    // handshake on the input side
    assign s_axis_tready = (state == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign coef_we       = in_beat && s_axis_tuser &&
                           (TAP_ARG_W'(in_coef_index) < TAP_ARG_W'(NUM_TAPS));
    assign samp_we       = in_beat && !s_axis_tuser;
    assign coef_waddr    = TAP_AW'(in_coef_index);
    assign out_free      = !r_out_valid || m_axis_tready;

    // filter enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_wdata;
        end
    end

    // newest-sample pointer of the circular delay line
    assign ptr_next = (r_ptr == TAP_AW'(NUM_TAPS - 1)) ? '0 : r_ptr + TAP_AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (samp_we) begin
            r_ptr <= ptr_next;
        end
    end

    // tap k of the delay line sits k places behind the newest sample
    assign ptr_diff = PTR_W'(r_ptr) - PTR_W'(tap);
    assign d_raddr  = (r_ptr >= tap) ? TAP_AW'(ptr_diff)
                                     : TAP_AW'(ptr_diff + PTR_W'(NUM_TAPS));

    // valid bits: an entry never written reads as its reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvalid <= '0;
            r_cvalid <= '0;
        end else begin
            if (samp_we) begin
                r_dvalid[ptr_next] <= 1'b1;
            end
            if (coef_we) begin
                r_cvalid[coef_waddr] <= 1'b1;
            end
        end
    end

    // valid flags and coefficient address aligned with the registered ram reads
    always_ff @(posedge i_clk) begin
        r_dvld_rd  <= r_dvalid[d_raddr];
        r_cvld_rd  <= r_cvalid[tap];
        r_caddr_rd <= tap;
    end

    fir49_ram #(
        .WIDTH  (SAMPLE_BITS),
        .DEPTH  (NUM_TAPS),
        .ADDR_W (TAP_AW)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (samp_we),
        .i_waddr (ptr_next),
        .i_wdata (in_sample),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    fir49_ram #(
        .WIDTH  (COEF_W),
        .DEPTH  (NUM_TAPS),
        .ADDR_W (TAP_AW)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (in_coef_value),
        .i_raddr (tap),
        .o_rdata (c_rdata)
    );

    // operands for the multiplier
    assign mac_sample = r_dvld_rd ? $signed(d_rdata) : '0;
    assign mac_coef   = r_cvld_rd ? $signed(c_rdata) : default_tap(TAP_ARG_W'(r_caddr_rd));

    fir49_seq #(
        .NUM_TAPS (NUM_TAPS),
        .TAP_AW   (TAP_AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start_mac (samp_we && r_enable),
        .i_start_raw (samp_we && !r_enable),
        .i_out_free  (out_free),
        .o_state     (state),
        .o_tap       (tap),
        .o_ctrl      (mac_ctrl),
        .o_emit      (emit)
    );

    fir49_mac #(
        .NUM_TAPS    (NUM_TAPS),
        .FRAC_BITS   (FRAC_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_ctrl   (mac_ctrl),
        .i_coef   (mac_coef),
        .i_sample (mac_sample),
        .o_result (mac_result)
    );

    // raw sample kept for the pass-through path
    always_ff @(posedge i_clk) begin
        if (samp_we) begin
            r_raw     <= OUT_W'(in_sample);
            r_use_raw <= !r_enable;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= r_use_raw ? r_raw : mac_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_data);

`ifndef ASSERT_OFF
    // a coefficient write completes in the cycle it is taken
    a_coef_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && s_axis_tuser) |=> (state == ST_IDLE))
        else $error("coefficient beat left the idle state");

    // a sample with filtering off goes straight to the output stage
    a_raw_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (samp_we && !r_enable) |=> (state == ST_EMIT))
        else $error("pass-through sample did not reach the output stage");

    // the output register is only loaded when it is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_valid || m_axis_tready))
        else $error("result loaded over a pending output beat");

    // the accumulator is only stepped while walking the taps
    a_acc_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mac_ctrl.acc_en || mac_ctrl.mul_en) |-> (state == ST_MAC))
        else $error("multiply-accumulate stepped outside the tap walk");
`endif

endmodule

// ----- hdl/fir49_ram.sv -----
// fir49_ram: generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module fir49_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 49,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/fir49_mac.sv -----
// fir49_mac: shared multiply-accumulate unit with scaling toward zero
// depends on fir49_pkg (t_mac_ctrl, widths)
`timescale 1ns / 1ps

module fir49_mac
    import fir49_pkg::*;
#(
    parameter int NUM_TAPS    = DEFAULT_NUM_TAPS,
    parameter int FRAC_BITS   = DEFAULT_FRAC_BITS,
    parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  t_mac_ctrl                     i_ctrl,
    input  logic signed [COEF_W-1:0]      i_coef,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [OUT_W-1:0]       o_result
);

    localparam int PROD_W = COEF_W + SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + $clog2(NUM_TAPS + 1);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  bias;
    logic signed [ACC_W-1:0]  biased;
    logic signed [ACC_W-1:0]  shifted;
    logic signed [OUT_W-1:0]  r_result;

    // product register, one tap per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_coef * i_sample;
        end
    end

    // accumulator
    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.clear) begin
            n_acc = '0;
        end else if (i_ctrl.acc_en) begin
            n_acc = r_acc + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // divide by 2^frac, truncating toward zero: bias negative sums before the shift
    assign bias    = r_acc[ACC_W-1] ? $signed({{(ACC_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}})
                                    : '0;
    assign biased  = r_acc + bias;
    assign shifted = biased >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.scale) begin
            r_result <= shifted[OUT_W-1:0];
        end
    end

    assign o_result = r_result;

endmodule

// ----- hdl/fir49_filter_top_note.sv -----
// fir49_seq: tap sequencer, walks the taps and steers the shared multiply-accumulate unit
// depends on fir49_pkg (t_state, t_mac_ctrl)
`timescale 1ns / 1ps

module fir49_seq
    import fir49_pkg::*;
#(
    parameter int NUM_TAPS = DEFAULT_NUM_TAPS,
    parameter int TAP_AW   = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start_mac,
    input  logic              i_start_raw,
    input  logic              i_out_free,
    output t_state            o_state,
    output logic [TAP_AW-1:0] o_tap,
    output t_mac_ctrl         o_ctrl,
    output logic              o_emit
);

    localparam int CNT_W = $clog2(NUM_TAPS + 2);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    // state and tap counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state and unit control
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        o_ctrl        = '0;
        o_emit        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ctrl.clear = 1'b1;
                n_cnt        = '0;
                if (i_start_mac) begin
                    n_state = ST_MAC;
                end else if (i_start_raw) begin
                    n_state = ST_EMIT;
                end
            end
            ST_MAC: begin
                // ram read issued at a tap's count, then the product is registered, then accumulated
                o_ctrl.mul_en = (r_cnt >= CNT_W'(1)) && (r_cnt <= CNT_W'(NUM_TAPS));
                o_ctrl.acc_en = (r_cnt >= CNT_W'(2));
                n_cnt         = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_TAPS + 1)) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                o_ctrl.scale = 1'b1;
                n_state      = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_out_free) begin
                    o_emit  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_state = r_state;
    assign o_tap   = r_cnt[TAP_AW-1:0];

endmodule

// ----- tb/sv/fir_tb_pkg.sv -----
// fir_tb_pkg: beat codes and field positions shared by the filter testbench files
// depends on fir49_pkg for the coefficient and index widths
`timescale 1ns / 1ps

package fir_tb_pkg;

    // kind of an input beat, carried on tuser
    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_COEF   = 1'b1
    } t_op;

    localparam int TAP_COUNT  = 49;
    localparam int SAMPLE_W   = 16;
    localparam int FRAC_W     = 21;

    // input tdata layout, lowest field first
    localparam int SAMPLE_LSB = 0;
    localparam int INDEX_LSB  = SAMPLE_LSB + SAMPLE_W;
    localparam int WEIGHT_LSB = INDEX_LSB + fir49_pkg::IDX_W;
    localparam int IN_W       = ((WEIGHT_LSB + fir49_pkg::COEF_W + 7) / 8) * 8;

endpackage

// ----- tb/sv/fir_checker.sv -----
// fir_checker: watches the filter's stream and config ports, predicts every output beat
// depends on fir49_pkg and fir_tb_pkg; reports a running failure count to the bench top
`timescale 1ns / 1ps

module fir_checker
    import fir49_pkg::*;
    import fir_tb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_wdata,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [IN_W-1:0]        i_in_data,   // sample, coef_index, coef_value, zero pad
    input  logic                   i_in_op,     // op
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [OUT_TDATA_W-1:0] i_out_data,  // filtered, zero pad
    output int                     o_fail_count,
    output int                     o_pending
);

    // low-pass weights loaded at reset, 21 fraction bits
    localparam logic signed [COEF_W-1:0] RESET_WEIGHTS [TAP_COUNT] = '{
        9733, 15471, -5049, -14911, 6848, 128, -19624, 8336, 9183, -27925,
        6391, 23983, -37599, -2252, 46682, -47138, -22805, 83041, -55201,
        -70793, 157703, -60603, -252402, 603816, 1335599, 603816, -252402,
        -60603, 157703, -70793, -55201, 83041, -22805, -47138, 46682, -2252,
        -37599, 23983, 6391, -27925, 9183, 8336, -19624, 128, 6848, -14911,
        -5049, 15471, 9733
    };

    logic signed [SAMPLE_W-1:0] sample_hist [TAP_COUNT];
    logic signed [COEF_W-1:0]   tap_weight  [TAP_COUNT];
    logic                       filter_on;
    logic [OUT_W-1:0]           filtered_q [$];
    int                         mismatches;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        mismatches   = 0;
    end

    always @(posedge i_clk) begin : predict
        longint                     acc;
        longint                     mag;
        logic signed [SAMPLE_W-1:0] smp;
        logic [IDX_W-1:0]           idx;
        logic [OUT_W-1:0]           want;
        logic [OUT_TDATA_W-1:0]     want_beat;

        if (!i_rst_n) begin
            filter_on = 1'b0;
            for (int i = 0; i < TAP_COUNT; i++) begin
                sample_hist[i] = '0;
                tap_weight[i]  = RESET_WEIGHTS[i];
            end
            filtered_q.delete();
        end else begin
            if (i_cfg_we) begin
                filter_on = i_cfg_wdata;
            end

            // input beat: weight update or new sample
            if (i_in_valid && i_in_ready) begin
                if (t_op'(i_in_op) == OP_COEF) begin
                    idx = i_in_data[INDEX_LSB +: IDX_W];
                    if (idx < TAP_COUNT) begin
                        tap_weight[idx] = i_in_data[WEIGHT_LSB +: COEF_W];
                    end
                end else begin
                    smp = i_in_data[SAMPLE_LSB +: SAMPLE_W];
                    for (int i = TAP_COUNT - 1; i > 0; i--) begin
                        sample_hist[i] = sample_hist[i-1];
                    end
                    sample_hist[0] = smp;
                    if (filter_on) begin
                        acc = 0;
                        for (int i = 0; i < TAP_COUNT; i++) begin
                            acc += longint'(tap_weight[i]) * longint'(sample_hist[i]);
                        end
                        // scale down with truncation toward zero
                        mag = (acc < 0) ? -acc : acc;
                        mag = mag >> FRAC_W;
                        acc = (acc < 0) ? -mag : mag;
                        want = acc[OUT_W-1:0];
                    end else begin
                        want = {{(OUT_W - SAMPLE_W){smp[SAMPLE_W-1]}}, smp};
                    end
                    filtered_q.push_back(want);
                end
            end

            // output beat against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (filtered_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected output beat: tdata %h", i_out_data);
                    end
                end else begin
                    want      = filtered_q.pop_front();
                    want_beat = {{(OUT_TDATA_W - OUT_W){1'b0}}, want};
                    if (i_out_data !== want_beat) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("filtered mismatch: expected %0d (tdata %h), got %0d (tdata %h)",
                                     $signed(want), want_beat,
                                     $signed(i_out_data[OUT_W-1:0]), i_out_data);
                        end
                    end
                end
            end
        end

        o_fail_count <= mismatches;
        o_pending    <= filtered_q.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// tb_top: stimulus and verdict for the 49-tap fir filter, checking done by fir_checker
// depends on fir49_pkg, fir_tb_pkg, fir_checker and the fir_filter_49_tap rtl
`timescale 1ns / 1ps

module tb_top;
    import fir49_pkg::*;
    import fir_tb_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS  = 130;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic                   i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_W-1:0]        s_axis_tdata;   // sample, coef_index, coef_value, zero pad
    logic                   s_axis_tuser;   // op
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // filtered, zero pad

    int fail_count;
    int pending;
    int idle_cycles;
    bit tx_burst;
    bit rx_burst;

    fir_filter_49_tap dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    fir_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_op      (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog on cycles without any accepted beat
    initial idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // output side: random hold-off before each beat, none during a burst
    initial begin : sink
        int gap;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            gap = rx_burst ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // one input beat; entered and left at a falling edge
    task automatic push_beat(input t_op op, input logic [SAMPLE_W-1:0] smp,
                             input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] weight);
        int               gap;
        logic [IN_W-1:0]  beat;
        gap  = tx_burst ? 0 : $urandom_range(0, 3);
        beat = '0;
        beat[SAMPLE_LSB +: SAMPLE_W] = smp;
        beat[INDEX_LSB +: IDX_W]     = idx;
        beat[WEIGHT_LSB +: COEF_W]   = weight;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // sample beat, unused fields filled with noise
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        push_beat(OP_SAMPLE, smp, IDX_W'($urandom), COEF_W'($urandom));
    endtask

    // weight write beat, unused sample field filled with noise
    task automatic send_weight(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] weight);
        push_beat(OP_COEF, SAMPLE_W'($urandom), idx, weight);
    endtask

    // drain all predicted beats, let the block settle, then write the enable
    task automatic set_filter(input logic en);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= en;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_item();
        int               pick;
        logic [SAMPLE_W-1:0] smp;
        logic [IDX_W-1:0]    idx;
        logic [COEF_W-1:0]   weight;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            case ($urandom_range(0, 9))
                0:       smp = 16'h7fff;
                1:       smp = 16'h8000;
                2:       smp = SAMPLE_W'($urandom_range(0, 15)) - 16'd8;
                default: smp = SAMPLE_W'($urandom);
            endcase
            send_sample(smp);
        end else begin
            // mostly real taps, now and then an index past the end
            idx = ($urandom_range(0, 7) == 0) ? IDX_W'($urandom_range(TAP_COUNT, 63))
                                              : IDX_W'($urandom_range(0, TAP_COUNT - 1));
            case ($urandom_range(0, 7))
                0:       weight = 24'h7fffff;
                1:       weight = 24'h800000;
                2:       weight = COEF_W'($urandom_range(0, 4095)) - 24'd2048;
                default: weight = COEF_W'($urandom);
            endcase
            send_weight(idx, weight);
        end
    endtask

    // main sequence
    initial begin : stimulus
        logic enables [5];
        enables = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_SAMPLE;
        tx_burst      = 1'b0;
        rx_burst      = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // pass-through after reset, delay line still fills
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hffff);
        send_sample(16'h0001);

        // default taps over the history so far
        set_filter(1'b1);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'd12345);
        send_sample(16'hffff);

        // weight extremes and ignored indices
        send_weight(6'd0, 24'h7fffff);
        send_weight(6'd48, 24'h800000);
        send_weight(6'd24, 24'h000000);
        send_weight(6'd49, 24'h0004d2);
        send_weight(6'd63, 24'hffffff);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'd100);
        send_sample(16'h8000);

        // random phases over both enable settings
        foreach (enables[p]) begin
            set_filter(enables[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) begin
                    tx_burst = ($urandom_range(0, 3) == 0);
                    rx_burst = ($urandom_range(0, 3) == 0);
                end
                random_item();
            end
        end

        // wait out the tail
        s_axis_tvalid <= 1'b0;
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
